/* rtl/vec3alu_pkg.sv */
// Shared types, constants and helpers of the three-component vector ALU.
// Used by the top level, the pipelined square root and the pipelined divider.
// No dependencies.
package vec3alu_pkg;

    // Operation codes carried in the func field of an item.
    typedef enum logic [2:0] {
        FUNC_ADD    = 3'd0,
        FUNC_SUB    = 3'd1,
        FUNC_CROSS  = 3'd2,
        FUNC_DOT    = 3'd3,
        FUNC_SCALE  = 3'd4,
        FUNC_LENGTH = 3'd5,
        FUNC_NORM   = 3'd6
    } func_t;

    localparam int LANES       = 3;
    localparam int MULTS       = 6;
    localparam int SQRT_STAGES = 32;
    localparam int SUMSQ_W     = 64;
    localparam int LEN_W       = 33;
    localparam int WIDE_W      = 66;

    localparam logic signed [WIDE_W-1:0] MAX_WIDE = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] MIN_WIDE = -66'sd2147483648;
    localparam logic signed [31:0]       MAX_WORD = 32'sh7FFF_FFFF;
    localparam logic signed [31:0]       MIN_WORD = 32'sh8000_0000;

    // One input item.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale_factor;
    } cmd_item_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar;
        logic               fault;
    } res_item_t;

    // Item state carried alongside the square root pipeline.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar;
        logic               fault;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
    } mid_t;

    // Item state carried alongside the divider pipeline.
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] scalar;
        logic               fault;
        logic [LANES-1:0]   neg;
    } fin_t;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    // Clamp a wide signed value into 32 bits and report overflow.
    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
        sat_t s;
        s.ovf = 1'b0;
        s.val = v[31:0];
        if (v > MAX_WIDE)
        begin
            s.ovf = 1'b1;
            s.val = MAX_WORD;
        end
        else if (v < MIN_WIDE)
        begin
            s.ovf = 1'b1;
            s.val = MIN_WORD;
        end
        return s;
    endfunction

endpackage

/* rtl/vec3alu_isqrt.sv */
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on vec3alu_pkg; carries an opaque sideband word with each item.
module vec3alu_isqrt
    import vec3alu_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [SUMSQ_W-1:0] in_n,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic [LEN_W-1:0]   out_root,
    output logic [SIDE_W-1:0]  out_side
);

    logic               valid_reg [SQRT_STAGES];
    logic [SUMSQ_W-1:0] rem_reg   [SQRT_STAGES];
    logic [SUMSQ_W-1:0] root_reg  [SQRT_STAGES];
    logic [SIDE_W-1:0]  side_reg  [SQRT_STAGES];

    logic               valid_in  [SQRT_STAGES];
    logic [SUMSQ_W-1:0] rem_in    [SQRT_STAGES];
    logic [SUMSQ_W-1:0] root_in   [SQRT_STAGES];
    logic [SIDE_W-1:0]  side_in   [SQRT_STAGES];
    logic [SUMSQ_W-1:0] rem_next  [SQRT_STAGES];
    logic [SUMSQ_W-1:0] root_next [SQRT_STAGES];

    // Each stage tries one bit of the root against the running remainder.
    always_comb
    begin
        logic [SUMSQ_W-1:0] bit_w;
        logic [SUMSQ_W-1:0] trial;
        for (int k = 0; k < SQRT_STAGES; k++)
        begin
            if (k == 0)
            begin
                valid_in[k] = in_valid;
                rem_in[k]   = in_n;
                root_in[k]  = '0;
                side_in[k]  = in_side;
            end
            else
            begin
                valid_in[k] = valid_reg[k-1];
                rem_in[k]   = rem_reg[k-1];
                root_in[k]  = root_reg[k-1];
                side_in[k]  = side_reg[k-1];
            end
            bit_w = SUMSQ_W'(1) << (2 * (SQRT_STAGES - 1 - k));
            trial = root_in[k] + bit_w;
            if (rem_in[k] >= trial)
            begin
                rem_next[k]  = rem_in[k] - trial;
                root_next[k] = (root_in[k] >> 1) + bit_w;
            end
            else
            begin
                rem_next[k]  = rem_in[k];
                root_next[k] = root_in[k] >> 1;
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                valid_reg[k] <= valid_in[k];
            end
        end
    end

    // Stage data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_in[k];
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1][LEN_W-1:0];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

/* rtl/vec3alu_ndiv.sv */
// Pipelined restoring divider for normalize: three lanes of |a| * 2^FRAC_BITS / len.
// Depends on vec3alu_pkg; carries an opaque sideband word with each item.
module vec3alu_ndiv
    import vec3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [LEN_W-1:0]                 in_len,
    input  logic [LANES-1:0][31:0]           in_mag,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic [LEN_W-1:0]                 out_len,
    output logic [LANES-1:0][FRAC_BITS:0]    out_quo,
    output logic [SIDE_W-1:0]                out_side
);

    // One stage for the integer bit, then one per fraction bit.
    localparam int ST    = FRAC_BITS + 1;
    localparam int REM_W = LEN_W + 1;

    logic                 valid_reg [ST];
    logic [LEN_W-1:0]     len_reg   [ST];
    logic [SIDE_W-1:0]    side_reg  [ST];
    logic [REM_W-1:0]     rem_reg   [ST][LANES];
    logic [FRAC_BITS:0]   quo_reg   [ST][LANES];

    logic                 valid_in  [ST];
    logic [LEN_W-1:0]     len_in    [ST];
    logic [SIDE_W-1:0]    side_in   [ST];
    logic [REM_W-1:0]     rem_next  [ST][LANES];
    logic [FRAC_BITS:0]   quo_next  [ST][LANES];

    // Each stage shifts the remainder and subtracts the length where it fits.
    always_comb
    begin
        logic [REM_W-1:0]   cand;
        logic [FRAC_BITS:0] quo_in;
        logic               ge;
        for (int j = 0; j < ST; j++)
        begin
            if (j == 0)
            begin
                valid_in[j] = in_valid;
                len_in[j]   = in_len;
                side_in[j]  = in_side;
            end
            else
            begin
                valid_in[j] = valid_reg[j-1];
                len_in[j]   = len_reg[j-1];
                side_in[j]  = side_reg[j-1];
            end
            for (int l = 0; l < LANES; l++)
            begin
                if (j == 0)
                begin
                    cand   = REM_W'(in_mag[l]);
                    quo_in = '0;
                end
                else
                begin
                    cand   = {rem_reg[j-1][l][REM_W-2:0], 1'b0};
                    quo_in = quo_reg[j-1][l];
                end
                ge = (cand >= REM_W'(len_in[j]));
                rem_next[j][l] = ge ? (cand - REM_W'(len_in[j])) : cand;
                quo_next[j][l] = {quo_in[FRAC_BITS-1:0], ge};
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ST; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int j = 0; j < ST; j++)
            begin
                valid_reg[j] <= valid_in[j];
            end
        end
    end

    // Stage data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < ST; j++)
            begin
                len_reg[j]  <= len_in[j];
                side_reg[j] <= side_in[j];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[j][l] <= rem_next[j][l];
                    quo_reg[j][l] <= quo_next[j][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[ST-1];
    assign out_len   = len_reg[ST-1];
    assign out_side  = side_reg[ST-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quo[l] = quo_reg[ST-1][l];
        end
    end

endmodule

/* rtl/vec3_arithmetic_unit_top.sv */
// Three-component vector ALU on signed fixed point, fully pipelined.
// Pipeline stages, Q16.16 with the default FRAC_BITS of 16:
// multiply, combine, 32 square root stages, FRAC_BITS + 1 divider stages, output.
// Throughput: one item per cycle; a stalled result holds the whole pipeline in place.
// Reset: asynchronous, active low; clears all valid bits, so the pipeline comes up empty.
// Depends on vec3alu_pkg, vec3alu_isqrt and vec3alu_ndiv.
module vec3_arithmetic_unit_top
    import vec3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    localparam int MID_W = $bits(mid_t);
    localparam int FIN_W = $bits(fin_t);

    logic en;

    logic                     s1_valid_reg;
    cmd_item_t                s1_item_reg;
    logic signed [63:0]       p_reg  [MULTS];
    logic signed [63:0]       p_next [MULTS];
    logic signed [31:0]       op_a   [MULTS];
    logic signed [31:0]       op_b   [MULTS];

    logic                     s2_valid_reg;
    mid_t                     mid_reg;
    mid_t                     mid_next;
    logic [SUMSQ_W-1:0]       sumsq_reg;
    logic [SUMSQ_W-1:0]       sumsq_next;

    logic                     sq_valid;
    logic [LEN_W-1:0]         sq_root;
    logic [MID_W-1:0]         sq_side;
    mid_t                     sq_mid;
    fin_t                     fin_in;
    logic [LANES-1:0][31:0]   mag;

    logic                     dv_valid;
    logic [LEN_W-1:0]         dv_len;
    logic [LANES-1:0][FRAC_BITS:0] dv_quo;
    logic [FIN_W-1:0]         dv_side;
    fin_t                     dv_fin;

    logic                     res_valid_reg;
    res_item_t                res_reg;
    res_item_t                res_next;

    // The whole pipeline moves unless a finished item waits at the output.
    assign en        = !res_valid_reg || !res_stall;
    assign cmd_stall = !en;

    // Stage 1: route operands to the six multipliers.
    always_comb
    begin
        op_a[0] = cmd.a_x;  op_b[0] = cmd.a_x;
        op_a[1] = cmd.a_y;  op_b[1] = cmd.a_y;
        op_a[2] = cmd.a_z;  op_b[2] = cmd.a_z;
        op_a[3] = cmd.a_x;  op_b[3] = cmd.b_z;
        op_a[4] = cmd.a_x;  op_b[4] = cmd.b_y;
        op_a[5] = cmd.a_y;  op_b[5] = cmd.b_x;
        case (cmd.func)
            FUNC_CROSS:
            begin
                op_a[0] = cmd.a_y;  op_b[0] = cmd.b_z;
                op_a[1] = cmd.a_z;  op_b[1] = cmd.b_y;
                op_a[2] = cmd.a_z;  op_b[2] = cmd.b_x;
            end
            FUNC_DOT:
            begin
                op_b[0] = cmd.b_x;
                op_b[1] = cmd.b_y;
                op_b[2] = cmd.b_z;
            end
            FUNC_SCALE:
            begin
                op_b[0] = cmd.scale_factor;
                op_b[1] = cmd.scale_factor;
                op_b[2] = cmd.scale_factor;
            end
            default:
            begin
                op_b[0] = cmd.a_x;
            end
        endcase
        for (int k = 0; k < MULTS; k++)
        begin
            p_next[k] = 64'(op_a[k]) * 64'(op_b[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= cmd;
            for (int k = 0; k < MULTS; k++)
            begin
                p_reg[k] <= p_next[k];
            end
        end
    end

    // Stage 2: floor the products, combine them and saturate.
    always_comb
    begin
        logic signed [WIDE_W-1:0] fl [MULTS];
        sat_t sx;
        sat_t sy;
        sat_t sz;
        sat_t ss;
        for (int k = 0; k < MULTS; k++)
        begin
            fl[k] = WIDE_W'(p_reg[k] >>> FRAC_BITS);
        end
        sx = '0;
        sy = '0;
        sz = '0;
        ss = '0;
        mid_next.fault = 1'b0;
        case (s1_item_reg.func)
            FUNC_ADD:
            begin
                sx = sat32(WIDE_W'(s1_item_reg.a_x) + WIDE_W'(s1_item_reg.b_x));
                sy = sat32(WIDE_W'(s1_item_reg.a_y) + WIDE_W'(s1_item_reg.b_y));
                sz = sat32(WIDE_W'(s1_item_reg.a_z) + WIDE_W'(s1_item_reg.b_z));
            end
            FUNC_SUB:
            begin
                sx = sat32(WIDE_W'(s1_item_reg.a_x) - WIDE_W'(s1_item_reg.b_x));
                sy = sat32(WIDE_W'(s1_item_reg.a_y) - WIDE_W'(s1_item_reg.b_y));
                sz = sat32(WIDE_W'(s1_item_reg.a_z) - WIDE_W'(s1_item_reg.b_z));
            end
            FUNC_CROSS:
            begin
                sx = sat32(fl[0] - fl[1]);
                sy = sat32(fl[2] - fl[3]);
                sz = sat32(fl[4] - fl[5]);
            end
            FUNC_DOT:
            begin
                ss = sat32(fl[0] + fl[1] + fl[2]);
            end
            FUNC_SCALE:
            begin
                sx = sat32(fl[0]);
                sy = sat32(fl[1]);
                sz = sat32(fl[2]);
            end
            FUNC_LENGTH, FUNC_NORM:
            begin
                sx = '0;
            end
            default:
            begin
                mid_next.fault = 1'b1;
            end
        endcase
        mid_next.func   = s1_item_reg.func;
        mid_next.r_x    = sx.val;
        mid_next.r_y    = sy.val;
        mid_next.r_z    = sz.val;
        mid_next.scalar = ss.val;
        mid_next.fault  = mid_next.fault | sx.ovf | sy.ovf | sz.ovf | ss.ovf;
        mid_next.a_x    = s1_item_reg.a_x;
        mid_next.a_y    = s1_item_reg.a_y;
        mid_next.a_z    = s1_item_reg.a_z;
        // Squares are never negative, so the raw bits add as unsigned.
        sumsq_next = $unsigned(p_reg[0]) + $unsigned(p_reg[1]) + $unsigned(p_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg   <= mid_next;
            sumsq_reg <= sumsq_next;
        end
    end

    // Square root of the sum of squares gives the length.
    vec3alu_isqrt #(
        .SIDE_W (MID_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_n      (sumsq_reg),
        .in_side   (mid_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Split A into magnitudes and signs for the divider.
    always_comb
    begin
        sq_mid        = mid_t'(sq_side);
        mag[0]        = sq_mid.a_x[31] ? 32'(-sq_mid.a_x) : sq_mid.a_x;
        mag[1]        = sq_mid.a_y[31] ? 32'(-sq_mid.a_y) : sq_mid.a_y;
        mag[2]        = sq_mid.a_z[31] ? 32'(-sq_mid.a_z) : sq_mid.a_z;
        fin_in.func   = sq_mid.func;
        fin_in.r_x    = sq_mid.r_x;
        fin_in.r_y    = sq_mid.r_y;
        fin_in.r_z    = sq_mid.r_z;
        fin_in.scalar = sq_mid.scalar;
        fin_in.fault  = sq_mid.fault;
        fin_in.neg    = {sq_mid.a_z[31], sq_mid.a_y[31], sq_mid.a_x[31]};
    end

    vec3alu_ndiv #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (FIN_W)
    ) u_ndiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_len    (sq_root),
        .in_mag    (mag),
        .in_side   (fin_in),
        .out_valid (dv_valid),
        .out_len   (dv_len),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // Output stage: place length or normalized vector into the result item; other codes pass through.
    always_comb
    begin
        dv_fin          = fin_t'(dv_side);
        res_next.r_x    = dv_fin.r_x;
        res_next.r_y    = dv_fin.r_y;
        res_next.r_z    = dv_fin.r_z;
        res_next.scalar = dv_fin.scalar;
        res_next.fault  = dv_fin.fault;
        case (dv_fin.func)
            FUNC_LENGTH:
            begin
                if (dv_len > LEN_W'(MAX_WORD))
                begin
                    res_next.scalar = MAX_WORD;
                    res_next.fault  = 1'b1;
                end
                else
                begin
                    res_next.scalar = dv_len[31:0];
                end
            end
            FUNC_NORM:
            begin
                if (dv_len == '0)
                begin
                    res_next.fault = 1'b1;
                end
                else
                begin
                    res_next.r_x = dv_fin.neg[0] ? -32'(dv_quo[0]) : 32'(dv_quo[0]);
                    res_next.r_y = dv_fin.neg[1] ? -32'(dv_quo[1]) : 32'(dv_quo[1]);
                    res_next.r_z = dv_fin.neg[2] ? -32'(dv_quo[2]) : 32'(dv_quo[2]);
                end
            end
            default:
            begin
                res_next.fault = dv_fin.fault;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // No result carries both a nonzero vector and a nonzero scalar.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.scalar == '0) ||
                      (res.r_x == '0 && res.r_y == '0 && res.r_z == '0))
        else $error("result has both vector and scalar parts");

    // A normalized component never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && dv_fin.func == FUNC_NORM && dv_len != '0 |->
            dv_quo[0] <= {1'b1, {FRAC_BITS{1'b0}}} &&
            dv_quo[1] <= {1'b1, {FRAC_BITS{1'b0}}} &&
            dv_quo[2] <= {1'b1, {FRAC_BITS{1'b0}}})
        else $error("normalize quotient above one");

    // While the output is held, the early stages keep their items.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> s1_valid_reg == $past(s1_valid_reg) &&
                s2_valid_reg == $past(s2_valid_reg) &&
                dv_valid == $past(dv_valid))
        else $error("pipeline moved during a stall");

endmodule

/* bench/vec3_arithmetic_unit_checker.sv */
// Checker for the three-component vector ALU: watches both channels, predicts each
// result from the accepted command item and compares it field by field.
// Depends on vec3alu_pkg.
`timescale 1ns / 100ps
module vec3_arithmetic_unit_checker
    import vec3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  cmd_item_t cmd,
    input  logic      res_valid,
    input  logic      res_stall,
    input  res_item_t res,
    output int        errors,
    output int        pending
);

    res_item_t expected_q[$];

    // Product shifted right by the fraction bits, rounded toward minus infinity.
    function automatic logic signed [65:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [65:0] p;
        p = 66'(a) * 66'(b);
        return p >>> FRAC_BITS;
    endfunction

    // Integer square root, floored.
    function automatic logic [63:0] floor_sqrt(input logic [65:0] n);
        logic [65:0] root;
        logic [65:0] bit_v;
        logic [65:0] rem;
        root = 0;
        rem = n;
        bit_v = 66'd1 << 64;
        while (bit_v > rem)
            bit_v = bit_v >> 2;
        while (bit_v != 0)
        begin
            if (rem >= root + bit_v)
            begin
                rem = rem - (root + bit_v);
                root = (root >> 1) + bit_v;
            end
            else
                root = root >> 1;
            bit_v = bit_v >> 2;
        end
        return root[63:0];
    endfunction

    // Normalized component: (a << FRAC_BITS) / len, truncated toward zero.
    function automatic logic signed [65:0] norm_comp(input logic signed [31:0] a,
                                                     input logic [63:0] len);
        logic [95:0] mag;
        logic [95:0] q;
        mag = (a < 0) ? 96'(-64'(a)) : 96'(a);
        q = (mag << FRAC_BITS) / 96'(len);
        return (a < 0) ? -66'(q) : 66'(q);
    endfunction

    // Clamp to 32 bits, raising the fault on overflow.
    function automatic logic signed [31:0] clamp(input logic signed [65:0] v,
                                                 inout logic flt);
        if (v > 66'sd2147483647)
        begin
            flt = 1'b1;
            return MAX_WORD;
        end
        if (v < -66'sd2147483648)
        begin
            flt = 1'b1;
            return MIN_WORD;
        end
        return v[31:0];
    endfunction

    // Expected result of one command item.
    function automatic res_item_t vec_result(input cmd_item_t c);
        logic signed [65:0] x;
        logic signed [65:0] y;
        logic signed [65:0] z;
        logic signed [65:0] s;
        logic [65:0] sq;
        logic [63:0] len;
        logic flt;
        res_item_t r;
        x = 0;
        y = 0;
        z = 0;
        s = 0;
        flt = 1'b0;
        sq = 66'(66'(c.a_x) * 66'(c.a_x)) + 66'(66'(c.a_y) * 66'(c.a_y))
             + 66'(66'(c.a_z) * 66'(c.a_z));
        case (c.func)
            FUNC_ADD:
            begin
                x = 66'(c.a_x) + 66'(c.b_x);
                y = 66'(c.a_y) + 66'(c.b_y);
                z = 66'(c.a_z) + 66'(c.b_z);
            end
            FUNC_SUB:
            begin
                x = 66'(c.a_x) - 66'(c.b_x);
                y = 66'(c.a_y) - 66'(c.b_y);
                z = 66'(c.a_z) - 66'(c.b_z);
            end
            FUNC_CROSS:
            begin
                x = fx_mul(c.a_y, c.b_z) - fx_mul(c.a_z, c.b_y);
                y = fx_mul(c.a_z, c.b_x) - fx_mul(c.a_x, c.b_z);
                z = fx_mul(c.a_x, c.b_y) - fx_mul(c.a_y, c.b_x);
            end
            FUNC_DOT:
                s = fx_mul(c.a_x, c.b_x) + fx_mul(c.a_y, c.b_y) + fx_mul(c.a_z, c.b_z);
            FUNC_SCALE:
            begin
                x = fx_mul(c.a_x, c.scale_factor);
                y = fx_mul(c.a_y, c.scale_factor);
                z = fx_mul(c.a_z, c.scale_factor);
            end
            FUNC_LENGTH:
                s = 66'(floor_sqrt(sq));
            FUNC_NORM:
            begin
                len = floor_sqrt(sq);
                if (len == 0)
                    flt = 1'b1;
                else
                begin
                    x = norm_comp(c.a_x, len);
                    y = norm_comp(c.a_y, len);
                    z = norm_comp(c.a_z, len);
                end
            end
            default:
                flt = 1'b1;
        endcase
        r.r_x = clamp(x, flt);
        r.r_y = clamp(y, flt);
        r.r_z = clamp(z, flt);
        r.scalar = clamp(s, flt);
        r.fault = flt;
        return r;
    endfunction

    assign pending = expected_q.size();

    // Queue a prediction per accepted command and check each accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        res_item_t e;
        if (!rst_n)
        begin
            errors <= 0;
            expected_q.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with no expectation waiting");
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (res !== e)
                    begin
                        if (res.r_x !== e.r_x)
                            $error("r_x expected %h actual %h", e.r_x, res.r_x);
                        if (res.r_y !== e.r_y)
                            $error("r_y expected %h actual %h", e.r_y, res.r_y);
                        if (res.r_z !== e.r_z)
                            $error("r_z expected %h actual %h", e.r_z, res.r_z);
                        if (res.scalar !== e.scalar)
                            $error("scalar expected %h actual %h", e.scalar, res.scalar);
                        if (res.fault !== e.fault)
                            $error("fault expected %b actual %b", e.fault, res.fault);
                        errors <= errors + 1;
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_q.push_back(vec_result(cmd));
        end
    end

endmodule

/* bench/vec3_arithmetic_unit_top_test.sv */
// Stimulus and verdict for the three-component vector ALU: directed and random
// command items with random idling on both channels. Depends on vec3alu_pkg,
// vec3_arithmetic_unit_top and vec3_arithmetic_unit_checker.
`timescale 1ns / 100ps
module vec3_arithmetic_unit_top_test;
    import vec3alu_pkg::*;

    localparam int RANDOM_ITEMS = 1330;
    localparam int QUIET_ITEMS  = 200;
    localparam int CYCLE_LIMIT  = 400000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      res_valid;
    logic      res_stall;
    res_item_t res;
    int        errors;
    int        pending;
    int        cycles;
    bit        quiet;

    vec3_arithmetic_unit_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    vec3_arithmetic_unit_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout guard.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("vec3_arithmetic_unit_top_test: FAIL");
                $finish;
            end
        end
    end

    // Result side stalls in random bursts until the quiet tail.
    initial
    begin
        int n;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 30);
            repeat (n) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // Random component: mix of extremes, small values and full range.
    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return MAX_WORD;
            1: return MIN_WORD;
            2: return $signed($urandom_range(0, 'h3FFFF)) - 32'sh20000;
            3: return 32'($urandom_range(0, 3)) - 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Send one item, holding it until accepted; optional idle burst first.
    task automatic send_item(input cmd_item_t c);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic send_ops(input logic [2:0] f, input logic signed [31:0] a,
                            input logic signed [31:0] b);
        cmd_item_t c;
        c.func = f;
        c.a_x = a;
        c.a_y = a;
        c.a_z = a;
        c.b_x = b;
        c.b_y = b;
        c.b_z = b;
        c.scale_factor = b;
        send_item(c);
    endtask

    initial
    begin
        cmd_item_t c;
        int k;
        quiet = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every code on extremes, saturation, zero normalize, unknown code.
        for (k = 0; k < 8; k++)
            send_ops(3'(k), MAX_WORD, MAX_WORD);
        for (k = 0; k < 8; k++)
            send_ops(3'(k), MIN_WORD, 32'sh0001_0000);
        send_ops(FUNC_NORM, 32'sd0, 32'sd0);
        send_ops(FUNC_LENGTH, 32'sd0, 32'sd0);
        send_ops(FUNC_NORM, 32'sd1, 32'sd0);
        send_ops(FUNC_SCALE, -32'sd1, -32'sd1);
        send_ops(FUNC_SUB, MIN_WORD, MAX_WORD);
        send_ops(FUNC_DOT, MIN_WORD, MIN_WORD);

        // Random items; the last stretch runs with no idling.
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            quiet = (k >= RANDOM_ITEMS - QUIET_ITEMS);
            c.func = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
            c.a_x = rand_comp();
            c.a_y = rand_comp();
            c.a_z = rand_comp();
            c.b_x = rand_comp();
            c.b_y = rand_comp();
            c.b_z = rand_comp();
            c.scale_factor = rand_comp();
            send_item(c);
        end
        cmd_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("vec3_arithmetic_unit_top_test: PASS");
        else
            $display("vec3_arithmetic_unit_top_test: FAIL");
        $finish;
    end

endmodule

/* vec3_arithmetic_unit_top.f */
rtl/vec3alu_pkg.sv
rtl/vec3alu_isqrt.sv
rtl/vec3alu_ndiv.sv
rtl/vec3_arithmetic_unit_top.sv
bench/vec3_arithmetic_unit_checker.sv
bench/vec3_arithmetic_unit_top_test.sv
